// ===== rtl/bpmc_pkg.sv =====
package bpmc_pkg;

    // Width of all stored timestamps; time math wraps at this width.
    localparam int TIME_WIDTH = 32;

    localparam int SECOND_MS          = 1000;
    localparam int BALANCE_PERIOD_MS  = 200;
    localparam int BALANCE_HOLDOFF_MS = 15000;

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEP_REQ_LAST = STEP_W'(10);
    localparam logic [STEP_W-1:0] STEP_SEQ_LAST = STEP_W'(60);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BALANCE_START = 3'd0,
        CFG_BALANCE_HYST  = 3'd1,
        CFG_CHARGE_TARGET = 3'd2,
        CFG_CHARGE_HYST   = 3'd3,
        CFG_OVER_TEMP     = 3'd4,
        CFG_UNDER_VOLT    = 3'd5,
        CFG_OVER_VOLT     = 3'd6,
        CFG_UNDER_DUR     = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_BOOT   = 3'd0,
        MODE_READY  = 3'd1,
        MODE_DRIVE  = 3'd2,
        MODE_CHARGE = 3'd3,
        MODE_ERROR  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_REQUEST    = 3'd1,
        ACT_UPDATE     = 3'd2,
        ACT_SEND       = 3'd3,
        ACT_SEND_CLEAR = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        CEND_NONE = 2'd0,
        CEND_FULL = 2'd1,
        CEND_95   = 2'd2
    } t_cend;

    typedef struct packed {
        logic [12:0]        balance_start_mv;
        logic [8:0]         balance_hyst_mv;
        logic [12:0]        charge_target_mv;
        logic [9:0]         charge_hyst_mv;
        logic signed [11:0] over_temp_decic;
        logic [12:0]        under_volt_mv;
        logic [12:0]        over_volt_mv;
        logic [15:0]        under_duration_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               key_on;
        logic [12:0]        avg_cell_mv;
        logic [12:0]        high_cell_mv;
        logic [12:0]        low_cell_mv;
        logic signed [11:0] high_temp_decic;
    } t_in_beat;

    typedef struct packed {
        t_mode   mode;
        logic    charger_on;
        logic    balancing;
        t_action balance_action;
        t_cend   charge_end;
    } t_out_beat;

endpackage

// ===== rtl/bpmc_if.sv =====
interface bpmc_in_if import bpmc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bpmc_out_if import bpmc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bpmc_cfg_regs.sv =====
module bpmc_cfg_regs import bpmc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.balance_start_mv  <= 13'd3900;
            r_cfg.balance_hyst_mv   <= 9'd5;
            r_cfg.charge_target_mv  <= 13'd4000;
            r_cfg.charge_hyst_mv    <= 10'd110;
            r_cfg.over_temp_decic   <= 12'sd650;
            r_cfg.under_volt_mv     <= 13'd2000;
            r_cfg.over_volt_mv      <= 13'd4250;
            r_cfg.under_duration_ms <= 16'd5000;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BALANCE_START: r_cfg.balance_start_mv  <= i_cfg_data[12:0];
                CFG_BALANCE_HYST:  r_cfg.balance_hyst_mv   <= i_cfg_data[8:0];
                CFG_CHARGE_TARGET: r_cfg.charge_target_mv  <= i_cfg_data[12:0];
                CFG_CHARGE_HYST:   r_cfg.charge_hyst_mv    <= i_cfg_data[9:0];
                CFG_OVER_TEMP:     r_cfg.over_temp_decic   <= $signed(i_cfg_data[11:0]);
                CFG_UNDER_VOLT:    r_cfg.under_volt_mv     <= i_cfg_data[12:0];
                CFG_OVER_VOLT:     r_cfg.over_volt_mv      <= i_cfg_data[12:0];
                CFG_UNDER_DUR:     r_cfg.under_duration_ms <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/bpmc_core.sv =====
module bpmc_core import bpmc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    bpmc_in_if.sink    i_in,
    bpmc_out_if.source o_out
);

    // input register and result register
    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;

    // controller state
    t_mode                 r_mode,      n_mode;
    logic                  r_bal,       n_bal;
    logic                  r_chg,       n_chg;
    logic [TIME_WIDTH-1:0] r_last_sec,  n_last_sec;
    logic [TIME_WIDTH-1:0] r_last_bal,  n_last_bal;
    logic [TIME_WIDTH-1:0] r_deadline,  n_deadline;
    logic [STEP_W-1:0]     r_step,      n_step;
    t_action               n_action;
    t_cend                 n_cend;

    logic advance;

    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] since_sec, since_bal, past_deadline;
    logic signed [13:0]    spread, charge_lim, full_lim;
    logic                  sec_tick, bal_tick, under_v, deadline_gone;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (advance) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) r_in <= i_in.data;
        if (advance) begin
            r_out.mode           <= n_mode;
            r_out.charger_on     <= n_chg;
            r_out.balancing      <= n_bal;
            r_out.balance_action <= n_action;
            r_out.charge_end     <= n_cend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_BOOT;
            r_bal      <= 1'b0;
            r_chg      <= 1'b0;
            r_last_sec <= '0;
            r_last_bal <= '0;
            r_deadline <= '0;
            r_step     <= '0;
        end else if (advance) begin
            r_mode     <= n_mode;
            r_bal      <= n_bal;
            r_chg      <= n_chg;
            r_last_sec <= n_last_sec;
            r_last_bal <= n_last_bal;
            r_deadline <= n_deadline;
            r_step     <= n_step;
        end
    end

    assign now = TIME_WIDTH'(r_in.now_ms);

    // signed views of the cell data; limits may go below zero
    assign spread     = $signed({1'b0, r_in.high_cell_mv}) - $signed({1'b0, r_in.low_cell_mv});
    assign charge_lim = $signed({1'b0, i_cfg.charge_target_mv})
                      - $signed({4'b0, i_cfg.charge_hyst_mv});
    assign full_lim   = $signed({1'b0, i_cfg.charge_target_mv})
                      - $signed({5'b0, i_cfg.balance_hyst_mv});

    assign since_sec     = now - r_last_sec;
    assign since_bal     = now - r_last_bal;
    assign past_deadline = now - r_deadline;
    assign sec_tick      = since_sec >= TIME_WIDTH'(SECOND_MS);
    assign bal_tick      = since_bal >= TIME_WIDTH'(BALANCE_PERIOD_MS);
    assign under_v       = (r_in.low_cell_mv < i_cfg.under_volt_mv)
                        || (r_in.high_cell_mv < i_cfg.under_volt_mv);
    // strictly past the deadline, wrap-safe
    assign deadline_gone = (past_deadline != '0) && !past_deadline[TIME_WIDTH-1];

    always_comb begin
        n_mode     = r_mode;
        n_bal      = r_bal;
        n_chg      = r_chg;
        n_last_sec = r_last_sec;
        n_last_bal = r_last_bal;
        n_deadline = r_deadline;
        n_step     = r_step;
        n_action   = ACT_NONE;
        n_cend     = CEND_NONE;

        unique case (r_mode)
            MODE_READY: begin
                n_chg = 1'b0;
                if (r_in.avg_cell_mv > i_cfg.balance_start_mv) begin
                    if (spread > $signed({4'b0, i_cfg.balance_hyst_mv, 1'b0}))
                        n_bal = 1'b1;
                    else if (spread <= $signed({5'b0, i_cfg.balance_hyst_mv}))
                        n_bal = 1'b0;
                end else begin
                    n_bal = 1'b0;
                end
                if ($signed({1'b0, r_in.high_cell_mv}) < charge_lim) n_mode = MODE_CHARGE;
                if (r_in.key_on) begin
                    n_bal  = 1'b0;
                    n_mode = MODE_DRIVE;
                end
            end
            MODE_DRIVE: begin
                if (!r_in.key_on) n_mode = MODE_READY;
            end
            MODE_CHARGE: begin
                n_bal = 1'b0;
                n_chg = 1'b1;
                if ((r_in.high_cell_mv > i_cfg.charge_target_mv)
                        || (r_in.high_temp_decic > i_cfg.over_temp_decic)) begin
                    n_cend = ($signed({1'b0, r_in.avg_cell_mv}) > full_lim) ? CEND_FULL
                                                                             : CEND_95;
                    n_chg  = 1'b0;
                    n_mode = MODE_READY;
                end
            end
            MODE_ERROR: begin
                n_chg = 1'b0;
                if ((r_in.low_cell_mv > i_cfg.under_volt_mv)
                        && (r_in.high_cell_mv < i_cfg.over_volt_mv))
                    n_mode = MODE_READY;
            end
            default: begin
                n_chg  = 1'b0;
                n_mode = MODE_READY;
            end
        endcase

        // once-a-second undervoltage watchdog
        if (sec_tick) begin
            n_last_sec = now;
            if (under_v) begin
                if (deadline_gone) n_mode = MODE_ERROR;
            end else begin
                n_deadline = now + TIME_WIDTH'(i_cfg.under_duration_ms);
            end
        end

        // balance sequence, one step per period
        if (bal_tick) begin
            n_last_bal = now;
            if (n_bal && (now > TIME_WIDTH'(BALANCE_HOLDOFF_MS))) begin
                if (r_step < STEP_REQ_LAST) begin
                    n_action = ACT_REQUEST;
                    n_step   = r_step + STEP_W'(1);
                end else if (r_step == STEP_REQ_LAST) begin
                    n_action = ACT_UPDATE;
                    n_step   = r_step + STEP_W'(1);
                end else if (r_step >= STEP_SEQ_LAST) begin
                    n_action = ACT_SEND_CLEAR;
                    n_step   = '0;
                end else begin
                    n_action = ACT_SEND;
                    n_step   = r_step + STEP_W'(1);
                end
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_SEQ_LAST)
        else $error("balance step count out of range");

    a_action_needs_bal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.balance_action != ACT_NONE) |-> r_out.balancing)
        else $error("balance step without balancing request");

    a_cend_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.charge_end != CEND_NONE)
            |-> (r_out.mode == MODE_READY) || (r_out.mode == MODE_ERROR))
        else $error("charge end reported outside ready or error");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register not loaded after advance");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_mode) && $stable(r_step) && $stable(r_deadline))
        else $error("controller state changed without an item");
`endif

endmodule

// ===== rtl/battery_pack_mode_controller.sv =====
// Battery pack mode controller.
// Input channel i_in: one beat per pass carries the millisecond timestamp, key
// input, average/highest/lowest cell voltage and highest temperature.
// Output channel o_out: exactly one beat per input beat with mode, charger
// enable, balancing request, balance sequence action and charge-end mark.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write one threshold register
// per clock; write only while no beat is in flight.
// Path: an accepted beat is held in the input register and its result is
// loaded into the output register once that register is free or being taken,
// which raises o_out.valid. Throughput: one beat per cycle while o_out.ready
// stays high; the whole mode update is one combinational pass between the
// input register and the result register.
// Stall: when o_out.ready is low the result holds, one more beat may still
// be taken into the input register, then i_in.ready drops.
// Reset (synchronous, i_rst_n low): mode boot, flags and timers cleared,
// thresholds back to defaults, both registers empty.
module battery_pack_mode_controller import bpmc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bpmc_in_if.sink               i_in,
    bpmc_out_if.source            o_out
);

    // threshold set; the user keeps it stable between passes, the block does not enforce it
    t_cfg cfg;

    bpmc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register, mode machine, watchdog, balance sequencer, result register
    bpmc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ===== tb/tb.sv =====
module tb;
    import bpmc_pkg::*;

    // Cycles with no beat on either channel and no config write before the run is called hung.
    localparam int STALL_LIMIT = 4000;
    // Long sink holdoff; the block holds at most two beats, then must stall i_in.
    localparam int HOLD_CYCLES = 400;
    // Padding after the last result is back, before cfg writes.
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BEATS = 325;
    localparam int N_ROWS = 25;

    localparam logic [TIME_WIDTH-1:0] HALF_RANGE = 1 << (TIME_WIDTH - 1);

    localparam t_cfg RESET_CFG = '{13'd3900, 9'd5, 13'd4000, 10'd110, 12'sd650,
                                   13'd2000, 13'd4250, 16'd5000};

    // Row check: typed means the expected status below is used as is.
    typedef struct packed {
        logic      typed;
        t_out_beat val;
    } t_want;

    typedef struct packed {
        t_in_beat beat;
        t_want    want;
    } t_dir_row;

    localparam t_want UNCHECKED = '0;

    // Kinds of random stretches; well-formed ones walk the mode machine.
    typedef enum logic [2:0] {
        EP_BALANCE,
        EP_CHARGE,
        EP_DRIVE,
        EP_UNDER,
        EP_NOISE
    } t_episode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bpmc_in_if  in_ch ();
    bpmc_out_if out_ch ();

    battery_pack_mode_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Pack controller model: own copy of state and thresholds.
    // ---------------------------------------------------------------
    t_cfg                  pack_cfg       = RESET_CFG;
    t_mode                 model_mode     = MODE_BOOT;
    logic                  model_balance  = 1'b0;
    logic                  model_charger  = 1'b0;
    logic [TIME_WIDTH-1:0] sec_mark_ms    = '0;
    logic [TIME_WIDTH-1:0] bal_mark_ms    = '0;
    logic [TIME_WIDTH-1:0] uv_deadline_ms = '0;
    logic [STEP_W-1:0]     bal_step       = '0;

    t_out_beat pending_status[$];   // expected status beats, oldest first
    t_want     row_checks[$];       // one per offered input beat

    int mismatches = 0;
    int out_count  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int holds_asked = 0;

    // Random stimulus cursor
    logic [31:0] now_cursor;
    t_episode    ep_kind = EP_NOISE;
    int          ep_left = 0;
    int          ep_pos  = 0;

    function automatic t_out_beat next_pack_status(t_in_beat b);
        t_out_beat             s;
        int                    avg, hi, lo, temp, spread;
        int                    start, bh, tgt, ch, ot, uv, ov;
        logic [TIME_WIDTH-1:0] now, gap;
        avg    = int'(b.avg_cell_mv);
        hi     = int'(b.high_cell_mv);
        lo     = int'(b.low_cell_mv);
        temp   = int'($signed(b.high_temp_decic));
        spread = hi - lo;   // negative on inconsistent cells
        start  = int'(pack_cfg.balance_start_mv);
        bh     = int'(pack_cfg.balance_hyst_mv);
        tgt    = int'(pack_cfg.charge_target_mv);
        ch     = int'(pack_cfg.charge_hyst_mv);
        ot     = int'($signed(pack_cfg.over_temp_decic));
        uv     = int'(pack_cfg.under_volt_mv);
        ov     = int'(pack_cfg.over_volt_mv);
        now    = b.now_ms;
        s.balance_action = ACT_NONE;
        s.charge_end     = CEND_NONE;

        case (model_mode)
            MODE_READY: begin
                model_charger = 1'b0;
                if (avg > start) begin
                    if (spread > 2 * bh) model_balance = 1'b1;
                    else if (spread <= bh) model_balance = 1'b0;
                end else begin
                    model_balance = 1'b0;
                end
                if (hi < tgt - ch) model_mode = MODE_CHARGE;
                if (b.key_on) begin
                    model_balance = 1'b0;
                    model_mode    = MODE_DRIVE;
                end
            end
            MODE_DRIVE: begin
                // charger enable left as it was
                if (!b.key_on) model_mode = MODE_READY;
            end
            MODE_CHARGE: begin
                model_balance = 1'b0;
                model_charger = 1'b1;
                if (hi > tgt || temp > ot) begin
                    s.charge_end  = (avg > tgt - bh) ? CEND_FULL : CEND_95;
                    model_charger = 1'b0;
                    model_mode    = MODE_READY;
                end
            end
            MODE_ERROR: begin
                model_charger = 1'b0;
                if (lo > uv && hi < ov) model_mode = MODE_READY;
            end
            default: begin
                model_charger = 1'b0;
                model_mode    = MODE_READY;
            end
        endcase

        // once a second: undervoltage watchdog, wrap-safe "strictly past"
        gap = now - sec_mark_ms;
        if (gap >= SECOND_MS) begin
            sec_mark_ms = now;
            if (lo < uv || hi < uv) begin
                gap = now - uv_deadline_ms;
                if (gap != 0 && gap < HALF_RANGE) model_mode = MODE_ERROR;
            end else begin
                uv_deadline_ms = now + TIME_WIDTH'(pack_cfg.under_duration_ms);
            end
        end

        // 200 ms balance sequence
        gap = now - bal_mark_ms;
        if (gap >= BALANCE_PERIOD_MS) begin
            bal_mark_ms = now;
            if (model_balance && now > BALANCE_HOLDOFF_MS) begin
                if (bal_step < STEP_REQ_LAST) begin
                    s.balance_action = ACT_REQUEST;
                    bal_step++;
                end else if (bal_step == STEP_REQ_LAST) begin
                    s.balance_action = ACT_UPDATE;
                    bal_step++;
                end else if (bal_step >= STEP_SEQ_LAST) begin
                    s.balance_action = ACT_SEND_CLEAR;
                    bal_step = '0;
                end else begin
                    s.balance_action = ACT_SEND;
                    bal_step++;
                end
            end
        end

        s.mode       = model_mode;
        s.charger_on = model_charger;
        s.balancing  = model_balance;
        return s;
    endfunction

    function automatic logic [12:0] clamp_mv(int v);
        if (v < 0) return 13'd0;
        if (v > 5000) return 13'd5000;
        return v[12:0];
    endfunction

    function automatic t_in_beat mk_in(logic [31:0] now, logic key, int avg, int hi,
                                       int lo, int temp);
        t_in_beat b;
        b.now_ms          = now;
        b.key_on          = key;
        b.avg_cell_mv     = avg[12:0];
        b.high_cell_mv    = hi[12:0];
        b.low_cell_mv     = lo[12:0];
        b.high_temp_decic = temp[11:0];
        return b;
    endfunction

    function automatic t_want typed_as(t_mode m, logic chg, logic bal, t_action a,
                                       t_cend e);
        t_want w;
        w.typed = 1'b1;
        w.val   = '{m, chg, bal, a, e};
        return w;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch: %s got %0d want %0d (status beat %0d)",
                     what, got, want, out_count);
    endtask

    // ---------------------------------------------------------------
    // Scoreboard: outputs checked first so a beat arriving with an empty
    // queue is flagged even if an input lands on the same edge.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_out_beat got, want;
        t_want     row;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (pending_status.size() == 0) begin
                    report_mismatch("status beat with nothing expected", int'(got), 0);
                end else begin
                    want = pending_status.pop_front();
                    if (got.mode !== want.mode)
                        report_mismatch("mode", int'(got.mode), int'(want.mode));
                    if (got.charger_on !== want.charger_on)
                        report_mismatch("charger_on", int'(got.charger_on),
                                        int'(want.charger_on));
                    if (got.balancing !== want.balancing)
                        report_mismatch("balancing", int'(got.balancing),
                                        int'(want.balancing));
                    if (got.balance_action !== want.balance_action)
                        report_mismatch("balance_action", int'(got.balance_action),
                                        int'(want.balance_action));
                    if (got.charge_end !== want.charge_end)
                        report_mismatch("charge_end", int'(got.charge_end),
                                        int'(want.charge_end));
                end
                out_count++;
            end
            if (in_ch.valid && in_ch.ready) begin
                want = next_pack_status(in_ch.data);
                row  = row_checks.pop_front();
                // typed rows override the model, model state still advances
                pending_status.push_back(row.typed ? row.val : want);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sink side: random ready, plus long holdoffs on request.
    // ---------------------------------------------------------------
    initial begin : sink_side
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holds_served != holds_asked) begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: ends the run after too many cycles with no traffic.
    // ---------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Source side helpers
    // ---------------------------------------------------------------
    task automatic send_beat(t_in_beat b, t_want w);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        row_checks.push_back(w);
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop offering until every expected status beat is back, then settle.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_status.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(t_cfg c);
        write_reg(CFG_BALANCE_START, CFG_DATA_W'(c.balance_start_mv));
        write_reg(CFG_BALANCE_HYST,  CFG_DATA_W'(c.balance_hyst_mv));
        write_reg(CFG_CHARGE_TARGET, CFG_DATA_W'(c.charge_target_mv));
        write_reg(CFG_CHARGE_HYST,   CFG_DATA_W'(c.charge_hyst_mv));
        write_reg(CFG_OVER_TEMP,     CFG_DATA_W'($signed(c.over_temp_decic)));
        write_reg(CFG_UNDER_VOLT,    CFG_DATA_W'(c.under_volt_mv));
        write_reg(CFG_OVER_VOLT,     CFG_DATA_W'(c.over_volt_mv));
        write_reg(CFG_UNDER_DUR,     CFG_DATA_W'(c.under_duration_ms));
        i_cfg_we <= 1'b0;
        pack_cfg = c;
    endtask

    // Next random pack sample; episodes are aimed at the current thresholds.
    task automatic next_pack_sample(output t_in_beat b);
        int          r, bh, tgt, ch_lim, uv, ov, ot, spread, avg, hi, lo;
        logic [31:0] step;
        bh     = int'(pack_cfg.balance_hyst_mv);
        tgt    = int'(pack_cfg.charge_target_mv);
        ch_lim = tgt - int'(pack_cfg.charge_hyst_mv);
        uv     = int'(pack_cfg.under_volt_mv);
        ov     = int'(pack_cfg.over_volt_mv);
        ot     = int'($signed(pack_cfg.over_temp_decic));

        if (ep_left == 0) begin
            r = $urandom_range(99);
            if (r < 28) begin
                ep_kind = EP_BALANCE;   // long ones may wrap the 61-step sequence
                ep_left = $urandom_range(180, 60);
            end else if (r < 50) begin
                ep_kind = EP_CHARGE;
                ep_left = $urandom_range(40, 8);
            end else if (r < 62) begin
                ep_kind = EP_DRIVE;
                ep_left = $urandom_range(20, 3);
            end else if (r < 80) begin
                ep_kind = EP_UNDER;
                ep_left = $urandom_range(40, 10);
            end else begin
                ep_kind = EP_NOISE;
                ep_left = $urandom_range(15, 3);
            end
            ep_pos = 0;
        end

        step = $urandom_range(250, 1);
        if ($urandom_range(9) == 0) step = 0;
        if (ep_kind == EP_UNDER) step = $urandom_range(1200, 200);
        if ($urandom_range(199) == 0) step = $urandom();     // far jump, wraps
        now_cursor += step;
        if (ep_kind == EP_NOISE && $urandom_range(3) == 0) now_cursor = $urandom();

        b.now_ms          = now_cursor;
        b.key_on          = 1'b0;
        b.high_temp_decic = 12'($urandom_range(600) - 100);
        avg = 3700;
        hi  = 3900;
        lo  = 3800;

        case (ep_kind)
            EP_BALANCE: begin
                r = $urandom_range(99);
                if (r < 80) spread = 2 * bh + $urandom_range(60, 1);
                else if (r < 90) spread = bh + $urandom_range(bh);   // hold band
                else spread = $urandom_range(bh);
                hi  = ch_lim + $urandom_range(200);
                lo  = hi - spread;
                avg = int'(pack_cfg.balance_start_mv) + $urandom_range(300, 1);
            end
            EP_CHARGE: begin
                if (ep_pos == 0) hi = ch_lim - $urandom_range(100, 1);
                else hi = ch_lim + ep_pos * $urandom_range(40);
                lo  = hi - $urandom_range(100);
                avg = tgt - bh + $urandom_range(20) - 10;   // both sides of the full mark
                if ($urandom_range(14) == 0) begin
                    r = ot + $urandom_range(50, 1);
                    if (r > 1500) r = 1500;
                    b.high_temp_decic = 12'(r);
                end
            end
            EP_DRIVE: begin
                b.key_on = (ep_left > 1);
                hi  = 3800 + $urandom_range(200);
                lo  = hi - $urandom_range(50);
                avg = lo + $urandom_range(20);
            end
            EP_UNDER: begin
                if (ep_left > 3) begin
                    lo = uv - $urandom_range(300, 1);
                    if ($urandom_range(4) == 0) hi = uv - $urandom_range(50, 1);
                    else hi = lo + $urandom_range(1500);
                end else begin
                    // back inside the window so error can clear
                    lo = uv + $urandom_range(200, 1);
                    hi = ov - $urandom_range(200, 1);
                end
                avg = (lo + hi) / 2;
            end
            default: begin
                b.key_on          = 1'($urandom_range(1));
                avg               = $urandom_range(5000);
                hi                = $urandom_range(5000);
                lo                = $urandom_range(5000);
                b.high_temp_decic = 12'($urandom_range(1900) - 400);
            end
        endcase

        b.avg_cell_mv  = clamp_mv(avg);
        b.high_cell_mv = clamp_mv(hi);
        b.low_cell_mv  = clamp_mv(lo);
        ep_left--;
        ep_pos++;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : source_side
        t_dir_row rows [N_ROWS];
        t_in_beat b;
        t_cfg     c;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_BALANCE_START;
        i_cfg_data  = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;

        // Directed rows under reset thresholds: charge limit 3890, full mark
        // 3995, over temp 650, window 2000..4250, 5 s undervoltage allowance.
        rows[0]  = '{mk_in(32'd0, 1'b0, 3700, 3950, 3700, 250),
                     typed_as(MODE_READY, 1'b0, 1'b0, ACT_NONE, CEND_NONE)};
        rows[1]  = '{mk_in(32'd10, 1'b1, 3700, 3950, 3700, 250),
                     typed_as(MODE_DRIVE, 1'b0, 1'b0, ACT_NONE, CEND_NONE)};
        rows[2]  = '{mk_in(32'd20, 1'b0, 3700, 3950, 3700, 250), UNCHECKED};
        rows[3]  = '{mk_in(32'd30, 1'b0, 3700, 3800, 3700, 250),
                     typed_as(MODE_CHARGE, 1'b0, 1'b0, ACT_NONE, CEND_NONE)};
        rows[4]  = '{mk_in(32'd40, 1'b0, 3700, 3850, 3700, 250),
                     typed_as(MODE_CHARGE, 1'b1, 1'b0, ACT_NONE, CEND_NONE)};
        // highest cell over target, average above full mark
        rows[5]  = '{mk_in(32'd50, 1'b0, 4000, 4001, 3950, 250),
                     typed_as(MODE_READY, 1'b0, 1'b0, ACT_NONE, CEND_FULL)};
        rows[6]  = '{mk_in(32'd60, 1'b0, 3700, 3800, 3700, 250), UNCHECKED};
        // over temperature, average below full mark
        rows[7]  = '{mk_in(32'd70, 1'b0, 3800, 3850, 3700, 651),
                     typed_as(MODE_READY, 1'b0, 1'b0, ACT_NONE, CEND_95)};
        // first second tick, undervoltage vs a deadline still at reset zero
        rows[8]  = '{mk_in(32'd1000, 1'b0, 3700, 3950, 1500, 250),
                     typed_as(MODE_ERROR, 1'b0, 1'b0, ACT_NONE, CEND_NONE)};
        rows[9]  = '{mk_in(32'd1010, 1'b0, 3700, 3950, 3700, 250), UNCHECKED};
        rows[10] = '{mk_in(32'd2000, 1'b0, 3700, 3950, 3700, 250), UNCHECKED};
        // under, but deadline still ahead
        rows[11] = '{mk_in(32'd3000, 1'b0, 3700, 3950, 1500, 250), UNCHECKED};
        rows[12] = '{mk_in(32'd8000, 1'b0, 3700, 3950, 1500, 250),
                     typed_as(MODE_ERROR, 1'b0, 1'b0, ACT_NONE, CEND_NONE)};
        rows[13] = '{mk_in(32'd8010, 1'b0, 3700, 3950, 1500, 250), UNCHECKED};
        rows[14] = '{mk_in(32'd8020, 1'b0, 3700, 4300, 3700, 250), UNCHECKED};
        rows[15] = '{mk_in(32'd8030, 1'b0, 3700, 3950, 3700, 250), UNCHECKED};
        // balancing past the 15 s holdoff: start, hold band, stop, bad cells
        rows[16] = '{mk_in(32'd16000, 1'b0, 3950, 4000, 3980, 250), UNCHECKED};
        rows[17] = '{mk_in(32'd16200, 1'b0, 3950, 4000, 3980, 250), UNCHECKED};
        rows[18] = '{mk_in(32'd16400, 1'b0, 3950, 4000, 3992, 250), UNCHECKED};
        rows[19] = '{mk_in(32'd16600, 1'b0, 3950, 4000, 3997, 250), UNCHECKED};
        rows[20] = '{mk_in(32'd16800, 1'b0, 3950, 3900, 3990, 250), UNCHECKED};
        rows[21] = '{mk_in(32'd16900, 1'b1, 3950, 4000, 3980, 250), UNCHECKED};
        // field extremes and timestamp wrap
        rows[22] = '{mk_in(32'hFFFF_FFFF, 1'b1, 5000, 5000, 5000, 1500), UNCHECKED};
        rows[23] = '{mk_in(32'd0, 1'b0, 0, 0, 0, -400), UNCHECKED};
        rows[24] = '{mk_in(32'h8000_0000, 1'b0, 0, 0, 0, -400), UNCHECKED};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 19;
        rx_idle_pct = 84;
        for (int i = 0; i < N_ROWS; i++) send_beat(rows[i].beat, rows[i].want);

        now_cursor = 32'd17000;
        for (int ph = 0; ph < 6; ph++) begin
            // idling: sender light / sink heavy, then swapped, then none
            if (ph < 2) begin
                tx_idle_pct = 19;
                rx_idle_pct = 84;
            end else if (ph < 4) begin
                tx_idle_pct = 84;
                rx_idle_pct = 19;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            case (ph)
                0: c = RESET_CFG;
                1: c = '{13'd0, 9'd0, 13'd0, 10'd0, -12'sd400, 13'd0, 13'd0, 16'd0};
                2: c = '{13'd5000, 9'd500, 13'd5000, 10'd1000, 12'sd1500,
                         13'd5000, 13'd5000, 16'd65535};
                5: c = '{13'd3600, 9'd20, 13'd4100, 10'd200, 12'sd450,
                         13'd2800, 13'd4200, 16'd1500};
                default: begin
                    c.balance_start_mv  = 13'($urandom_range(5000));
                    c.balance_hyst_mv   = 9'($urandom_range(500));
                    c.charge_target_mv  = 13'($urandom_range(5000));
                    c.charge_hyst_mv    = 10'($urandom_range(1000));
                    c.over_temp_decic   = 12'($urandom_range(1900) - 400);
                    c.under_volt_mv     = 13'($urandom_range(5000));
                    c.over_volt_mv      = 13'($urandom_range(5000));
                    c.under_duration_ms = 16'($urandom_range(65535));
                end
            endcase

            drain_results();
            apply_settings(c);

            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (ph == 4 && n == 100) holds_asked++;   // fill up, stall i_in
                if (ph == 5 && n == 150) drain_results(); // sender waits it out
                next_pack_sample(b);
                send_beat(b, UNCHECKED);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (pending_status.size() != 0)
            report_mismatch("status beats never seen", pending_status.size(), 0);

        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
